// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// CHK_ASSERT is checked only while rst_n is high.
// CHK_ASSERT_ALWAYS is checked at every clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ASSERT(lbl, prop, msg)
`define CHK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/ole_pkg.sv
`default_nettype none
package ole_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_READ   = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_PURGE  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  localparam int PosW  = 6;
  localparam int DataW = 64;
  localparam int KeyW  = 32;
  localparam int CntOutW = 7;

endpackage
`default_nettype wire

// File: hdl/ordered_list_engine.sv
// A request rejected up front, an append or a removal of the tail is finished from idle:
// its result is registered in the cycle after start. Other requests walk the entry memory
// in S_SCAN (at most one read and one write per cycle); an insert then writes its item in S_FIN.
// One item at a time: start is taken only in idle; busy is high while out of idle (S_SCAN, S_FIN).
// Reset (rst_n low, synchronous) empties the list; the entry memory is not cleared.
// Results are strobed on out_valid for one cycle and cannot be stalled.
`default_nettype none
`include "assert_macros.svh"
module ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_req_type,
  input  wire logic [ole_pkg::PosW-1:0]      in_position,
  input  wire logic [ole_pkg::DataW-1:0]     in_item_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [ole_pkg::DataW-1:0]          out_read_data,
  output logic [ole_pkg::PosW-1:0]           out_found_position,
  output logic [ole_pkg::CntOutW-1:0]        out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ole_pkg::PosW) ? CW : ole_pkg::PosW;

  ole_pkg::state_t  state_r, state_nxt;
  ole_pkg::req_t    op_r, op_nxt;
  logic [ole_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [ole_pkg::DataW-1:0] val_r, val_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    keep_r, keep_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    tag_r, tag_nxt;
  logic             iss_r, iss_nxt;
  logic             rv_r, rv_nxt;
  logic             out_valid_r, out_valid_nxt;
  ole_pkg::status_t out_status_r, out_status_nxt;
  logic [ole_pkg::DataW-1:0] out_read_data_r, out_read_data_nxt;
  logic [ole_pkg::PosW-1:0]  out_found_position_r, out_found_position_nxt;

  logic [ole_pkg::DataW-1:0] mem [CAPACITY];
  logic [ole_pkg::DataW-1:0] mem_q_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [ole_pkg::DataW-1:0] mem_wd;
  logic [AW-1:0]    mem_ra;

  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    cnt_ext;
  logic [AW-1:0]    last;
  logic             nomatch;
  logic [CW-1:0]    keep_fin;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::S_IDLE;
      cnt_r       <= '0;
      iss_r       <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r                 <= op_nxt;
    pos_r                <= pos_nxt;
    val_r                <= val_nxt;
    keep_r               <= keep_nxt;
    idx_r                <= idx_nxt;
    tag_r                <= tag_nxt;
    out_status_r         <= out_status_nxt;
    out_read_data_r      <= out_read_data_nxt;
    out_found_position_r <= out_found_position_nxt;
  end

  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(cnt_r);
  assign last     = AW'(cnt_r - CW'(1));
  assign nomatch  = (mem_q_r != val_r);
  assign keep_fin = keep_r + CW'(nomatch);

  always_comb begin
    state_nxt              = state_r;
    op_nxt                 = op_r;
    pos_nxt                = pos_r;
    val_nxt                = val_r;
    cnt_nxt                = cnt_r;
    keep_nxt               = keep_r;
    idx_nxt                = idx_r;
    tag_nxt                = idx_r;
    iss_nxt                = iss_r;
    rv_nxt                 = 1'b0;
    out_valid_nxt          = 1'b0;
    out_status_nxt         = out_status_r;
    out_read_data_nxt      = out_read_data_r;
    out_found_position_nxt = out_found_position_r;
    mem_we                 = 1'b0;
    mem_wa                 = AW'(in_position);
    mem_wd                 = in_item_value;
    mem_ra                 = idx_r;

    unique case (state_r)
      ole_pkg::S_IDLE: begin
        if (start) begin
          op_nxt                 = ole_pkg::req_t'(in_req_type);
          pos_nxt                = in_position;
          val_nxt                = in_item_value;
          keep_nxt               = '0;
          out_status_nxt         = ole_pkg::ST_OK;
          out_read_data_nxt      = '0;
          out_found_position_nxt = '0;
          unique case (ole_pkg::req_t'(in_req_type)) inside
            ole_pkg::REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ole_pkg::ST_BADPOS;
              end else if (cnt_r == CW'(CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ole_pkg::ST_FULL;
              end else if (pos_ext == cnt_ext) begin
                mem_we        = 1'b1;
                cnt_nxt       = cnt_r + CW'(1);
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = last;
                iss_nxt   = 1'b1;
                state_nxt = ole_pkg::S_SCAN;
              end
            end
            ole_pkg::REQ_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ole_pkg::ST_BADPOS;
              end else if (pos_ext == cnt_ext - PW'(1)) begin
                cnt_nxt       = cnt_r - CW'(1);
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt   = AW'(in_position) + AW'(1);
                iss_nxt   = 1'b1;
                state_nxt = ole_pkg::S_SCAN;
              end
            end
            ole_pkg::REQ_READ: begin
              if (pos_ext >= cnt_ext) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ole_pkg::ST_BADPOS;
              end else begin
                idx_nxt   = AW'(in_position);
                iss_nxt   = 1'b1;
                state_nxt = ole_pkg::S_SCAN;
              end
            end
            ole_pkg::REQ_FIND, ole_pkg::REQ_PURGE: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ole_pkg::ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                iss_nxt   = 1'b1;
                state_nxt = ole_pkg::S_SCAN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ole_pkg::ST_BADPOS;
            end
          endcase
        end
      end

      ole_pkg::S_SCAN: begin
        if (iss_r) begin
          rv_nxt = 1'b1;
          case (op_r)
            ole_pkg::REQ_INSERT: begin
              if (idx_r == AW'(pos_r)) begin
                iss_nxt = 1'b0;
              end else begin
                idx_nxt = idx_r - AW'(1);
              end
            end
            ole_pkg::REQ_READ: begin
              iss_nxt = 1'b0;
            end
            default: begin
              if (idx_r == last) begin
                iss_nxt = 1'b0;
              end else begin
                idx_nxt = idx_r + AW'(1);
              end
            end
          endcase
        end
        if (rv_r) begin
          mem_wd = mem_q_r;
          case (op_r)
            ole_pkg::REQ_INSERT: begin
              mem_we = 1'b1;
              mem_wa = tag_r + AW'(1);
              if (tag_r == AW'(pos_r)) begin
                state_nxt = ole_pkg::S_FIN;
              end
            end
            ole_pkg::REQ_REMOVE: begin
              mem_we = 1'b1;
              mem_wa = tag_r - AW'(1);
              if (tag_r == last) begin
                cnt_nxt       = cnt_r - CW'(1);
                out_valid_nxt = 1'b1;
                iss_nxt       = 1'b0;
                state_nxt     = ole_pkg::S_IDLE;
              end
            end
            ole_pkg::REQ_READ: begin
              out_read_data_nxt = mem_q_r;
              out_valid_nxt     = 1'b1;
              iss_nxt           = 1'b0;
              state_nxt         = ole_pkg::S_IDLE;
            end
            ole_pkg::REQ_FIND: begin
              if (mem_q_r[ole_pkg::KeyW-1:0] == val_r[ole_pkg::KeyW-1:0]) begin
                out_found_position_nxt = ole_pkg::PosW'(tag_r);
                out_valid_nxt          = 1'b1;
                iss_nxt                = 1'b0;
                state_nxt              = ole_pkg::S_IDLE;
              end else if (tag_r == last) begin
                out_status_nxt = ole_pkg::ST_NOTFOUND;
                out_valid_nxt  = 1'b1;
                iss_nxt        = 1'b0;
                state_nxt      = ole_pkg::S_IDLE;
              end
            end
            default: begin
              mem_we   = nomatch;
              mem_wa   = AW'(keep_r);
              keep_nxt = keep_fin;
              if (tag_r == last) begin
                if (keep_fin == cnt_r) begin
                  out_status_nxt = ole_pkg::ST_NOTFOUND;
                end else begin
                  cnt_nxt = keep_fin;
                end
                out_valid_nxt = 1'b1;
                iss_nxt       = 1'b0;
                state_nxt     = ole_pkg::S_IDLE;
              end
            end
          endcase
        end
      end

      ole_pkg::S_FIN: begin
        mem_we        = 1'b1;
        mem_wa        = AW'(pos_r);
        mem_wd        = val_r;
        cnt_nxt       = cnt_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = ole_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != ole_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_data      = out_read_data_r;
  assign out_found_position = out_found_position_r;
  assign out_entry_count    = ole_pkg::CntOutW'(cnt_r);

  `CHK_ASSERT(a_cnt_bound, cnt_r <= CW'(CAPACITY), "entry count above capacity")
  `CHK_ASSERT(a_write_in_list, mem_we |-> (CW'(mem_wa) <= cnt_r), "write beyond list end")
  `CHK_ASSERT(a_issue_in_scan, iss_r |-> (state_r == ole_pkg::S_SCAN), "read issued outside walk")
  `CHK_ASSERT(a_result_cause, out_valid_r |-> $past(busy || start), "result without an item")

endmodule
`default_nettype wire
